// ===== src/kwch_pkg.sv =====
// Shared constants and operation codes for the weighted color histogram.
package kwch_pkg;

   localparam int DEF_MAX_BINS  = 16;
   localparam int DEF_ACC_WIDTH = 32;

   localparam int OP_W       = 2;
   localparam int CHAN_W     = 4;
   localparam int WEIGHT_W   = 16;
   localparam int READ_BIN_W = 12;
   localparam int OUT_W      = 32;
   localparam int CFG_W      = 5;
   localparam int IDX_W      = 15;  // holds n^3 - 1 for any 5-bit n
   localparam int T_W        = 9;   // c1 * n + c2
   localparam int NSQ_W      = 10;  // n * n

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd0;
   localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ       = 2'd2;

endpackage

// ===== src/kwch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kwch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kwch_addr.sv =====
// Bin address unit: combined index by Horner steps, read index range check.
module kwch_addr import kwch_pkg::*; #(
   parameter int MAX_BINS_PER_CHANNEL = DEF_MAX_BINS
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [CFG_W-1:0]      n_eff,
   input  logic [CHAN_W-1:0]     chan1_bin,
   input  logic [CHAN_W-1:0]     chan2_bin,
   input  logic [CHAN_W-1:0]     chan3_bin,
   input  logic [READ_BIN_W-1:0] read_bin,
   output logic [$clog2(MAX_BINS_PER_CHANNEL * MAX_BINS_PER_CHANNEL
                        * MAX_BINS_PER_CHANNEL)-1:0] acc_addr,
   output logic [$clog2(MAX_BINS_PER_CHANNEL * MAX_BINS_PER_CHANNEL
                        * MAX_BINS_PER_CHANNEL)-1:0] read_addr,
   output logic                  read_ok
);

   localparam int DEPTH = MAX_BINS_PER_CHANNEL * MAX_BINS_PER_CHANNEL
                          * MAX_BINS_PER_CHANNEL;
   localparam int AW    = $clog2(DEPTH);

   logic [T_W-1:0]        t_ff,   t_in;
   logic [NSQ_W-1:0]      nsq_ff, nsq_in;
   logic [CHAN_W-1:0]     c3_ff;
   logic [READ_BIN_W-1:0] rb_ff;
   logic [IDX_W-1:0]      idx;
   logic [IDX_W-1:0]      cube;

   // first step: c1 * n + c2 and n * n
   assign t_in   = T_W'(IDX_W'(chan1_bin) * IDX_W'(n_eff) + IDX_W'(chan2_bin));
   assign nsq_in = NSQ_W'(IDX_W'(n_eff) * IDX_W'(n_eff));

   always_ff @(posedge clock) begin
      if (load) begin
         t_ff   <= t_in;
         nsq_ff <= nsq_in;
         c3_ff  <= chan3_bin;
         rb_ff  <= read_bin;
      end
   end

   // second step: (c1 * n + c2) * n + c3, and n^3 for the read bound
   assign idx  = IDX_W'(t_ff) * IDX_W'(n_eff) + IDX_W'(c3_ff);
   assign cube = IDX_W'(nsq_ff) * IDX_W'(n_eff);

   assign acc_addr  = idx[AW-1:0];
   assign read_addr = AW'(rb_ff);
   assign read_ok   = IDX_W'(rb_ff) < cube;

endmodule

// ===== src/kernel_weighted_color_histogram.sv =====
// Top level: kernel-weighted 3D color histogram with RAM bin store.
//
//  channel | ports                      | handshake
//  --------+----------------------------+----------------------------------
//  request | req_*                      | beat when start high, busy low
//  result  | rsp_*                      | rsp_strobe for one cycle, no stall
//  config  | csr_write_en, csr_bins_... | written at clock edges with csr_write_en high
//
// Accumulate and read pass from accept to result through the address step,
// the RAM read, then add and write back for accumulate or the bin value for
// read. busy drops as the result shows, so the next beat can be taken in that
// cycle. A read at or past n^3 is flagged in the lookup cycle and answered with status set.
// Clear, unknown op and bad channel bins answer the cycle after accept.
// Clear then sweeps the store, one entry a cycle, over all MAX_BINS_PER_CHANNEL^3
// entries (4096 at default) with busy high; reset runs the same sweep.
module kernel_weighted_color_histogram import kwch_pkg::*; #(
   parameter int MAX_BINS_PER_CHANNEL = DEF_MAX_BINS,
   parameter int ACC_WIDTH            = DEF_ACC_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [CHAN_W-1:0]     req_chan1_bin,
   input  logic [CHAN_W-1:0]     req_chan2_bin,
   input  logic [CHAN_W-1:0]     req_chan3_bin,
   input  logic [WEIGHT_W-1:0]   req_kernel_weight,
   input  logic [READ_BIN_W-1:0] req_read_bin,
   output logic                  rsp_strobe,
   output logic [OUT_W-1:0]      rsp_bin_value,
   output logic [OUT_W-1:0]      rsp_total_weight,
   output logic                  rsp_status,
   input  logic                  csr_write_en,
   input  logic [CFG_W-1:0]      csr_bins_per_channel
);

   localparam int DEPTH = MAX_BINS_PER_CHANNEL * MAX_BINS_PER_CHANNEL
                          * MAX_BINS_PER_CHANNEL;
   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = ACC_WIDTH + 1;
   localparam int EXT_W = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CLR  = 2'd1;
   localparam logic [1:0] ST_LOOK = 2'd2;
   localparam logic [1:0] ST_UPD  = 2'd3;

   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                    input logic [WEIGHT_W-1:0]  w);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(w);
      return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic [ACC_WIDTH-1:0] v);
      logic [EXT_W-1:0] e;
      e = EXT_W'(v);
      return (e > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
   endfunction

   logic [1:0]           state_ff, state_in;
   logic [CFG_W-1:0]     bins_ff;
   logic [ACC_WIDTH-1:0] total_ff, total_in;
   logic [AW-1:0]        clr_idx_ff, clr_idx_in;
   logic [OP_W-1:0]      op_ff;
   logic [WEIGHT_W-1:0]  w_ff;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_W-1:0]     rsp_bin_ff, rsp_bin_in;
   logic [OUT_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic [CFG_W-1:0]     n_eff;
   logic                 accept;
   logic                 chan_ok;
   logic [AW-1:0]        acc_addr, read_addr;
   logic                 read_ok;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr;
   logic [ACC_WIDTH-1:0] wr_data, rd_data;
   logic [ACC_WIDTH-1:0] bin_sum, total_sum;

   // register value clamped into 1..MAX_BINS_PER_CHANNEL
   always_comb begin
      if (bins_ff == '0) begin
         n_eff = CFG_W'(1);
      end else if ({1'b0, bins_ff} > (CFG_W + 1)'(MAX_BINS_PER_CHANNEL)) begin
         n_eff = CFG_W'(MAX_BINS_PER_CHANNEL);
      end else begin
         n_eff = bins_ff;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign chan_ok = ({1'b0, req_chan1_bin} < n_eff) && ({1'b0, req_chan2_bin} < n_eff)
                    && ({1'b0, req_chan3_bin} < n_eff);

   kwch_addr #(
      .MAX_BINS_PER_CHANNEL(MAX_BINS_PER_CHANNEL)
   ) u_addr (
      .clock     (clock),
      .load      (accept),
      .n_eff     (n_eff),
      .chan1_bin (req_chan1_bin),
      .chan2_bin (req_chan2_bin),
      .chan3_bin (req_chan3_bin),
      .read_bin  (req_read_bin),
      .acc_addr  (acc_addr),
      .read_addr (read_addr),
      .read_ok   (read_ok)
   );

   kwch_ram #(
      .WIDTH(ACC_WIDTH),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   assign bin_sum   = sat_add(rd_data, w_ff);
   assign total_sum = sat_add(total_ff, w_ff);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      clr_idx_in    = clr_idx_ff;
      addr_in       = (op_ff == OP_READ) ? read_addr : acc_addr;
      rsp_strobe_in = 1'b0;
      rsp_bin_in    = '0;
      rsp_total_in  = to_out(total_ff);
      rsp_status_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = bin_sum;
      rd_en         = 1'b0;
      case (state_ff)
         ST_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = '0;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(DEPTH - 1)) begin
               clr_idx_in = '0;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_CLEAR: begin
                     total_in      = '0;
                     clr_idx_in    = '0;
                     state_in      = ST_CLR;
                     rsp_strobe_in = 1'b1;
                     rsp_total_in  = '0;
                  end
                  OP_ACCUMULATE: begin
                     if (chan_ok) begin
                        state_in = ST_LOOK;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_LOOK;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if ((op_ff == OP_READ) && !read_ok) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = 1'b1;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            if (op_ff == OP_ACCUMULATE) begin
               wr_en        = 1'b1;
               total_in     = total_sum;
               rsp_total_in = to_out(total_sum);
            end else begin
               rsp_bin_in = to_out(rd_data);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         bins_ff       <= CFG_RESET;
         total_ff      <= '0;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_en) begin
            bins_ff <= csr_bins_per_channel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         w_ff  <= req_kernel_weight;
      end
      if (state_ff == ST_LOOK) begin
         addr_ff <= addr_in;
      end
      rsp_bin_ff    <= rsp_bin_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_bin_value    = rsp_bin_ff;
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_status       = rsp_status_ff;

   a_clear_zeroes_total: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_CLEAR) |=> (rsp_strobe && rsp_total_weight == '0))
      else $error("clear beat did not report a zero total");

   a_update_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> (rsp_strobe && !busy))
      else $error("update cycle gave no result or left busy high");

   a_sweep_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR && $past(state_ff == ST_CLR)) |-> !rsp_strobe)
      else $error("result beat during clear sweep");

   a_flag_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_bin_value == '0))
      else $error("flagged result carries a bin value");

endmodule
